// File: rtl/core/assert_macros.svh
// Assertion macros shared by the checker core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRMC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srmc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SRMC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srmc assertion failed");

`endif

// File: rtl/core/srmc_pkg.sv
package srmc_pkg;

    localparam int COUNT_BITS = 24;
    localparam int SUM_BITS   = 56;
    localparam int DATA_W     = 32;
    localparam int MEAN_W     = 31;
    localparam int FIELD_W    = 24;
    localparam int EN_W       = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int STEP_W     = $clog2(SUM_BITS);
    localparam int CNT_EXT_W  = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;

    localparam int EN_REPLACE = 0;
    localparam int EN_SCALE   = 1;
    localparam int EN_RANGE   = 2;
    localparam int EN_FLOOR   = 3;
    localparam int EN_CEIL    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MISSING_IN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISSING_OUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_MAX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLES     = 3'd7;

    localparam logic signed [DATA_W-1:0] SCALE_RESET = 32'sd65536;
    localparam logic [SUM_BITS-1:0]      SUM_MAX     = '1;
    localparam logic [COUNT_BITS-1:0]    COUNT_MAX   = '1;
    localparam logic [FIELD_W-1:0]       FIELD_MAX   = '1;
    localparam logic [MEAN_W-1:0]        MEAN_MAX    = '1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_SCALE = 7'b0000100,
        S_ACC   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_WARN  = 7'b0100000,
        S_OUT   = 7'b1000000
    } srmc_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } srmc_div_stat_t;

    function automatic logic [FIELD_W-1:0] clamp_count(input logic [COUNT_BITS-1:0] c);
        logic [CNT_EXT_W-1:0] ext;
        ext = CNT_EXT_W'(c);
        if (ext > CNT_EXT_W'(FIELD_MAX)) begin
            return FIELD_MAX;
        end
        return ext[FIELD_W-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] count_inc(input logic [COUNT_BITS-1:0] c);
        if (c == COUNT_MAX) begin
            return c;
        end
        return c + COUNT_BITS'(1);
    endfunction

endpackage

// File: rtl/core/srmc_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module srmc_divider (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [srmc_pkg::SUM_BITS-1:0]      dividend,
    input  logic [srmc_pkg::COUNT_BITS-1:0]    divisor,
    output logic [srmc_pkg::SUM_BITS-1:0]      quotient,
    output srmc_pkg::srmc_div_stat_t           stat
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [srmc_pkg::STEP_W-1:0]        step_reg;
    logic [srmc_pkg::COUNT_BITS-1:0]    rem_reg;
    logic [srmc_pkg::COUNT_BITS-1:0]    divisor_reg;
    logic [srmc_pkg::SUM_BITS-1:0]      quo_reg;
    logic [srmc_pkg::COUNT_BITS:0]      shifted;
    logic [srmc_pkg::COUNT_BITS:0]      diff;
    logic                               fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[srmc_pkg::SUM_BITS-1]};
        diff    = shifted - {1'b0, divisor_reg};
        fits    = shifted >= {1'b0, divisor_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + srmc_pkg::STEP_W'(1);
                if (step_reg == srmc_pkg::STEP_W'(srmc_pkg::SUM_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[srmc_pkg::COUNT_BITS-1:0]
                            : shifted[srmc_pkg::COUNT_BITS-1:0];
            quo_reg <= {quo_reg[srmc_pkg::SUM_BITS-2:0], fits};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: rtl/core/sample_range_and_mean_checker_core.sv
// A sample request passes in order through missing-code replacement on acceptance,
// the 32 by 32 scale multiply, rounding and saturation, accumulation, and the load of
// the output register, which waits while the output is stalled; only then can the next
// request be accepted. An evaluate request runs the divider, which forms the absolute
// mean one quotient bit per cycle over the 56-bit sum; when no sample has been counted
// the divider is skipped. One request is in work at a time; a finished result waits in
// the output register while the next request is accepted.
`include "assert_macros.svh"

module sample_range_and_mean_checker_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   cmd,
    input  logic signed [srmc_pkg::DATA_W-1:0]     sample_in,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [srmc_pkg::DATA_W-1:0]     sample_out,
    output logic                                   sample_missing,
    output logic [srmc_pkg::FIELD_W-1:0]           valid_count,
    output logic [srmc_pkg::FIELD_W-1:0]           below_count,
    output logic [srmc_pkg::FIELD_W-1:0]           above_count,
    output logic [srmc_pkg::MEAN_W-1:0]            mean_abs,
    output logic                                   mean_far_low,
    output logic                                   mean_low,
    output logic                                   mean_far_high,
    output logic                                   mean_high,
    input  logic                                   cfg_write,
    input  logic [srmc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [srmc_pkg::DATA_W-1:0]            cfg_data
);

    srmc_pkg::srmc_state_t state_reg;
    srmc_pkg::srmc_state_t state_next;

    logic signed [srmc_pkg::DATA_W-1:0] missing_in_reg;
    logic signed [srmc_pkg::DATA_W-1:0] missing_out_reg;
    logic signed [srmc_pkg::DATA_W-1:0] scale_reg;
    logic signed [srmc_pkg::DATA_W-1:0] valid_min_reg;
    logic signed [srmc_pkg::DATA_W-1:0] valid_max_reg;
    logic [srmc_pkg::MEAN_W-1:0]        floor_reg;
    logic [srmc_pkg::MEAN_W-1:0]        ceiling_reg;
    logic [srmc_pkg::EN_W-1:0]          enables_reg;

    logic [srmc_pkg::SUM_BITS-1:0]      abs_sum_reg;
    logic [srmc_pkg::COUNT_BITS-1:0]    sample_total_reg;
    logic [srmc_pkg::COUNT_BITS-1:0]    low_total_reg;
    logic [srmc_pkg::COUNT_BITS-1:0]    high_total_reg;
    logic [srmc_pkg::SUM_BITS-1:0]      abs_sum_next;
    logic [srmc_pkg::COUNT_BITS-1:0]    sample_total_next;
    logic [srmc_pkg::COUNT_BITS-1:0]    low_total_next;
    logic [srmc_pkg::COUNT_BITS-1:0]    high_total_next;

    logic signed [srmc_pkg::DATA_W-1:0]   x_reg;
    logic signed [2*srmc_pkg::DATA_W-1:0] prod_reg;
    logic                                 scale_on_reg;
    logic [srmc_pkg::MEAN_W-1:0]          mean_reg;

    logic signed [srmc_pkg::DATA_W-1:0] res_sample_reg;
    logic                               res_missing_reg;
    logic [srmc_pkg::FIELD_W-1:0]       res_valid_reg;
    logic [srmc_pkg::FIELD_W-1:0]       res_below_reg;
    logic [srmc_pkg::FIELD_W-1:0]       res_above_reg;
    logic [srmc_pkg::MEAN_W-1:0]        res_mean_reg;
    logic [3:0]                         res_warn_reg;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic                               out_free;
    logic                               accept;
    logic                               div_start;
    logic [srmc_pkg::SUM_BITS-1:0]      div_quotient;
    srmc_pkg::srmc_div_stat_t           div_stat;

    logic signed [srmc_pkg::DATA_W-1:0]   x_replaced;
    logic signed [2*srmc_pkg::DATA_W-1:0] rounded;
    logic signed [srmc_pkg::DATA_W-1:0]   x_scaled;
    logic                                 x_miss;
    logic                                 count_on;
    logic [srmc_pkg::DATA_W:0]            x_abs;
    logic [srmc_pkg::SUM_BITS:0]          sum_add;
    logic [srmc_pkg::MEAN_W+3:0]          mean_x10;
    logic [srmc_pkg::MEAN_W+3:0]          ceiling_x10;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != srmc_pkg::S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign div_start = accept && cmd && (sample_total_reg != '0);

    srmc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (abs_sum_reg),
        .divisor  (sample_total_reg),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    always_comb
    begin
        x_replaced = sample_in;
        if (enables_reg[srmc_pkg::EN_REPLACE] && (sample_in == missing_in_reg))
        begin
            x_replaced = missing_out_reg;
        end

        rounded  = (prod_reg + 64'sd32768) >>> 16;
        x_scaled = rounded[srmc_pkg::DATA_W-1:0];
        if (rounded > 64'sd2147483647)
        begin
            x_scaled = 32'sh7FFFFFFF;
        end
        else if (rounded < -64'sd2147483648)
        begin
            x_scaled = 32'sh80000000;
        end

        x_miss   = (x_reg == missing_out_reg);
        count_on = (enables_reg[srmc_pkg::EN_CEIL:srmc_pkg::EN_RANGE] != '0) && !x_miss;
        x_abs    = x_reg[srmc_pkg::DATA_W-1] ? (33'd0 - {x_reg[srmc_pkg::DATA_W-1], x_reg})
                                             : {1'b0, x_reg};
        sum_add  = {1'b0, abs_sum_reg} + (srmc_pkg::SUM_BITS + 1)'(x_abs);

        abs_sum_next      = abs_sum_reg;
        sample_total_next = sample_total_reg;
        low_total_next    = low_total_reg;
        high_total_next   = high_total_reg;
        if (count_on)
        begin
            abs_sum_next = sum_add[srmc_pkg::SUM_BITS] ? srmc_pkg::SUM_MAX
                                                       : sum_add[srmc_pkg::SUM_BITS-1:0];
            sample_total_next = srmc_pkg::count_inc(sample_total_reg);
            if (enables_reg[srmc_pkg::EN_RANGE])
            begin
                if (x_reg < valid_min_reg)
                begin
                    low_total_next = srmc_pkg::count_inc(low_total_reg);
                end
                if (x_reg > valid_max_reg)
                begin
                    high_total_next = srmc_pkg::count_inc(high_total_reg);
                end
            end
        end

        mean_x10    = {1'b0, mean_reg, 3'b000} + {3'b000, mean_reg, 1'b0};
        ceiling_x10 = {1'b0, ceiling_reg, 3'b000} + {3'b000, ceiling_reg, 1'b0};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srmc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (!cmd)
                    begin
                        state_next = srmc_pkg::S_MUL;
                    end
                    else if (div_start)
                    begin
                        state_next = srmc_pkg::S_DIV;
                    end
                    else
                    begin
                        state_next = srmc_pkg::S_WARN;
                    end
                end
            end
            srmc_pkg::S_MUL:   state_next = srmc_pkg::S_SCALE;
            srmc_pkg::S_SCALE: state_next = srmc_pkg::S_ACC;
            srmc_pkg::S_ACC:   state_next = srmc_pkg::S_OUT;
            srmc_pkg::S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = srmc_pkg::S_WARN;
                end
            end
            srmc_pkg::S_WARN:  state_next = srmc_pkg::S_OUT;
            srmc_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    state_next = srmc_pkg::S_IDLE;
                end
            end
            default:           state_next = srmc_pkg::S_IDLE;
        endcase

        out_valid_next = out_valid_reg && out_stall;
        if ((state_reg == srmc_pkg::S_OUT) && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= srmc_pkg::S_IDLE;
            out_valid_reg    <= 1'b0;
            missing_in_reg   <= '0;
            missing_out_reg  <= '0;
            scale_reg        <= srmc_pkg::SCALE_RESET;
            valid_min_reg    <= '0;
            valid_max_reg    <= '0;
            floor_reg        <= '0;
            ceiling_reg      <= '0;
            enables_reg      <= '0;
            abs_sum_reg      <= '0;
            sample_total_reg <= '0;
            low_total_reg    <= '0;
            high_total_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    srmc_pkg::REG_MISSING_IN:  missing_in_reg  <= cfg_data;
                    srmc_pkg::REG_MISSING_OUT: missing_out_reg <= cfg_data;
                    srmc_pkg::REG_SCALE:       scale_reg       <= cfg_data;
                    srmc_pkg::REG_VALID_MIN:   valid_min_reg   <= cfg_data;
                    srmc_pkg::REG_VALID_MAX:   valid_max_reg   <= cfg_data;
                    srmc_pkg::REG_FLOOR:       floor_reg   <= cfg_data[srmc_pkg::MEAN_W-1:0];
                    srmc_pkg::REG_CEILING:     ceiling_reg <= cfg_data[srmc_pkg::MEAN_W-1:0];
                    srmc_pkg::REG_ENABLES:     enables_reg <= cfg_data[srmc_pkg::EN_W-1:0];
                    default:                   ;
                endcase
            end

            if (state_reg == srmc_pkg::S_ACC)
            begin
                abs_sum_reg      <= abs_sum_next;
                sample_total_reg <= sample_total_next;
                low_total_reg    <= low_total_next;
                high_total_reg   <= high_total_next;
            end
            else if (state_reg == srmc_pkg::S_WARN)
            begin
                abs_sum_reg      <= '0;
                sample_total_reg <= '0;
                low_total_reg    <= '0;
                high_total_reg   <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            srmc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    x_reg    <= x_replaced;
                    mean_reg <= '0;
                end
            end
            srmc_pkg::S_MUL:
            begin
                prod_reg     <= (2*srmc_pkg::DATA_W)'(x_reg) * (2*srmc_pkg::DATA_W)'(scale_reg);
                scale_on_reg <= enables_reg[srmc_pkg::EN_SCALE] && !x_miss;
            end
            srmc_pkg::S_SCALE:
            begin
                if (scale_on_reg)
                begin
                    x_reg <= x_scaled;
                end
            end
            srmc_pkg::S_ACC:
            begin
                res_sample_reg  <= x_reg;
                res_missing_reg <= x_miss;
                res_valid_reg   <= srmc_pkg::clamp_count(sample_total_next);
                res_below_reg   <= srmc_pkg::clamp_count(low_total_next);
                res_above_reg   <= srmc_pkg::clamp_count(high_total_next);
                res_mean_reg    <= '0;
                res_warn_reg    <= '0;
            end
            srmc_pkg::S_DIV:
            begin
                if (div_stat.done)
                begin
                    mean_reg <= (div_quotient[srmc_pkg::SUM_BITS-1:srmc_pkg::MEAN_W] != '0)
                              ? srmc_pkg::MEAN_MAX : div_quotient[srmc_pkg::MEAN_W-1:0];
                end
            end
            srmc_pkg::S_WARN:
            begin
                res_sample_reg  <= '0;
                res_missing_reg <= 1'b0;
                res_valid_reg   <= srmc_pkg::clamp_count(sample_total_reg);
                res_below_reg   <= srmc_pkg::clamp_count(low_total_reg);
                res_above_reg   <= srmc_pkg::clamp_count(high_total_reg);
                res_mean_reg    <= mean_reg;
                res_warn_reg[3] <= enables_reg[srmc_pkg::EN_FLOOR]
                                   && (mean_x10 < (srmc_pkg::MEAN_W + 4)'(floor_reg));
                res_warn_reg[2] <= enables_reg[srmc_pkg::EN_FLOOR] && (mean_reg < floor_reg);
                res_warn_reg[1] <= enables_reg[srmc_pkg::EN_CEIL]
                                   && ((srmc_pkg::MEAN_W + 4)'(mean_reg) > ceiling_x10);
                res_warn_reg[0] <= enables_reg[srmc_pkg::EN_CEIL] && (mean_reg > ceiling_reg);
            end
            srmc_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    sample_out     <= res_sample_reg;
                    sample_missing <= res_missing_reg;
                    valid_count    <= res_valid_reg;
                    below_count    <= res_below_reg;
                    above_count    <= res_above_reg;
                    mean_abs       <= res_mean_reg;
                    mean_far_low   <= res_warn_reg[3];
                    mean_low       <= res_warn_reg[2];
                    mean_far_high  <= res_warn_reg[1];
                    mean_high      <= res_warn_reg[0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    `SRMC_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != srmc_pkg::S_IDLE)
    `SRMC_ASSERT_IMPL(a_div_only_in_div, div_stat.busy || div_stat.done, state_reg == srmc_pkg::S_DIV)
    `SRMC_ASSERT_IMPL(a_low_le_total, 1'b1, low_total_reg <= sample_total_reg)
    `SRMC_ASSERT_IMPL(a_high_le_total, 1'b1, high_total_reg <= sample_total_reg)
    `SRMC_ASSERT_NEXT(a_eval_clears, state_reg == srmc_pkg::S_WARN, sample_total_reg == '0 && abs_sum_reg == '0)

endmodule

// File: verif/srmc_checker.sv
package srmc_tb_pkg;

    localparam logic CMD_SAMPLE   = 1'b0;
    localparam logic CMD_EVALUATE = 1'b1;

endpackage

module srmc_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               cmd,
    input  logic signed [srmc_pkg::DATA_W-1:0] sample_in,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic signed [srmc_pkg::DATA_W-1:0] sample_out,
    input  logic                               sample_missing,
    input  logic [srmc_pkg::FIELD_W-1:0]       valid_count,
    input  logic [srmc_pkg::FIELD_W-1:0]       below_count,
    input  logic [srmc_pkg::FIELD_W-1:0]       above_count,
    input  logic [srmc_pkg::MEAN_W-1:0]        mean_abs,
    input  logic                               mean_far_low,
    input  logic                               mean_low,
    input  logic                               mean_far_high,
    input  logic                               mean_high,
    input  logic                               cfg_write,
    input  logic [srmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srmc_pkg::DATA_W-1:0]        cfg_data,
    output int                                 mismatches,
    output int                                 outstanding,
    output int                                 compared
);
    timeunit 1ns;
    timeprecision 1ps;

    import srmc_pkg::*;
    import srmc_tb_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] sample_out;
        logic                     missing;
        logic [FIELD_W-1:0]       valid_count;
        logic [FIELD_W-1:0]       below_count;
        logic [FIELD_W-1:0]       above_count;
        logic [MEAN_W-1:0]        mean_abs;
        logic                     far_low;
        logic                     low;
        logic                     far_high;
        logic                     high;
    } srmc_result_t;

    srmc_result_t pending_results[$];

    logic signed [DATA_W-1:0] code_old;
    logic signed [DATA_W-1:0] code_new;
    logic signed [DATA_W-1:0] gain;
    logic signed [DATA_W-1:0] lower_bound;
    logic signed [DATA_W-1:0] upper_bound;
    logic [MEAN_W-1:0]        floor_lim;
    logic [MEAN_W-1:0]        ceil_lim;
    logic [EN_W-1:0]          en_mask;

    logic [SUM_BITS-1:0]      sum_mag;
    logic [COUNT_BITS-1:0]    n_counted;
    logic [COUNT_BITS-1:0]    n_below;
    logic [COUNT_BITS-1:0]    n_above;

    function automatic logic signed [DATA_W-1:0] apply_gain(
        input logic signed [DATA_W-1:0] x,
        input logic signed [DATA_W-1:0] f
    );
        logic signed [63:0] prod;
        logic signed [63:0] q;
        prod = x * f;
        q = (prod + 64'sd32768) >>> 16;
        if (q > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end
        if (q < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return q[DATA_W-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    function automatic logic [FIELD_W-1:0] clamp_field(input logic [COUNT_BITS-1:0] c);
        logic [63:0] w;
        w = 64'(c);
        return (w > 64'(FIELD_MAX)) ? FIELD_MAX : w[FIELD_W-1:0];
    endfunction

    function automatic srmc_result_t predict_result(
        input logic                     c,
        input logic signed [DATA_W-1:0] s
    );
        srmc_result_t r;
        logic signed [DATA_W-1:0] x;
        logic [DATA_W-1:0] mag;
        logic [SUM_BITS:0] grown;
        logic [63:0] mean;
        r = '{default: '0};
        if (c == CMD_SAMPLE) begin
            x = s;
            if (en_mask[EN_REPLACE] && x == code_old) begin
                x = code_new;
            end
            if (en_mask[EN_SCALE] && x != code_new) begin
                x = apply_gain(x, gain);
            end
            r.missing = (x == code_new);
            if ((en_mask[EN_RANGE] || en_mask[EN_FLOOR] || en_mask[EN_CEIL]) && !r.missing)
            begin
                mag = (x < 0) ? -x : x;
                grown = {1'b0, sum_mag} + mag;
                sum_mag = grown[SUM_BITS] ? '1 : grown[SUM_BITS-1:0];
                n_counted = bump(n_counted);
                if (en_mask[EN_RANGE]) begin
                    if (x < lower_bound) begin
                        n_below = bump(n_below);
                    end
                    if (x > upper_bound) begin
                        n_above = bump(n_above);
                    end
                end
            end
            r.sample_out = x;
        end
        else begin
            mean = 0;
            if (n_counted != 0) begin
                mean = 64'(sum_mag) / 64'(n_counted);
                if (mean > 64'(MEAN_MAX)) begin
                    mean = 64'(MEAN_MAX);
                end
            end
            r.mean_abs = mean[MEAN_W-1:0];
            if (en_mask[EN_FLOOR]) begin
                r.far_low = (mean * 10 < 64'(floor_lim));
                r.low     = (mean < 64'(floor_lim));
            end
            if (en_mask[EN_CEIL]) begin
                r.far_high = (mean > 64'(ceil_lim) * 10);
                r.high     = (mean > 64'(ceil_lim));
            end
        end
        r.valid_count = clamp_field(n_counted);
        r.below_count = clamp_field(n_below);
        r.above_count = clamp_field(n_above);
        if (c == CMD_EVALUATE) begin
            sum_mag   = '0;
            n_counted = '0;
            n_below   = '0;
            n_above   = '0;
        end
        return r;
    endfunction

    task automatic compare_field(
        input string       field,
        input logic [31:0] want,
        input logic [31:0] got
    );
        if (want !== got) begin
            if (mismatches < 10) begin
                $display("%0t ns: %s expected 0x%08h, got 0x%08h", $time, field, want, got);
            end
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        srmc_result_t want;
        if (!rst_n) begin
            code_old    = '0;
            code_new    = '0;
            gain        = SCALE_RESET;
            lower_bound = '0;
            upper_bound = '0;
            floor_lim   = '0;
            ceil_lim    = '0;
            en_mask     = '0;
            sum_mag     = '0;
            n_counted   = '0;
            n_below     = '0;
            n_above     = '0;
            pending_results.delete();
            outstanding = 0;
            mismatches  = 0;
            compared    = 0;
        end
        else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_MISSING_IN:  code_old    = cfg_data;
                    REG_MISSING_OUT: code_new    = cfg_data;
                    REG_SCALE:       gain        = cfg_data;
                    REG_VALID_MIN:   lower_bound = cfg_data;
                    REG_VALID_MAX:   upper_bound = cfg_data;
                    REG_FLOOR:       floor_lim   = cfg_data[MEAN_W-1:0];
                    REG_CEILING:     ceil_lim    = cfg_data[MEAN_W-1:0];
                    REG_ENABLES:     en_mask     = cfg_data[EN_W-1:0];
                    default:         ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t ns: result arrived with no request waiting", $time);
                    end
                    mismatches++;
                end
                else begin
                    want = pending_results.pop_front();
                    compare_field("sample_out", want.sample_out, sample_out);
                    compare_field("sample_missing", want.missing, sample_missing);
                    compare_field("valid_count", want.valid_count, valid_count);
                    compare_field("below_count", want.below_count, below_count);
                    compare_field("above_count", want.above_count, above_count);
                    compare_field("mean_abs", want.mean_abs, mean_abs);
                    compare_field("mean_far_low", want.far_low, mean_far_low);
                    compare_field("mean_low", want.low, mean_low);
                    compare_field("mean_far_high", want.far_high, mean_far_high);
                    compare_field("mean_high", want.high, mean_high);
                    compared++;
                end
            end
            if (in_valid && !in_stall) begin
                pending_results.push_back(predict_result(cmd, sample_in));
            end
            outstanding = pending_results.size();
        end
    end

endmodule

// File: verif/sample_range_and_mean_checker_core_tb.sv
module sample_range_and_mean_checker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srmc_pkg::*;
    import srmc_tb_pkg::*;

    localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam int PHASES          = 12;
    localparam int PHASE_REQUESTS  = 145;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic                        cmd;
    logic signed [DATA_W-1:0]    sample_in;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [DATA_W-1:0]    sample_out;
    logic                        sample_missing;
    logic [FIELD_W-1:0]          valid_count;
    logic [FIELD_W-1:0]          below_count;
    logic [FIELD_W-1:0]          above_count;
    logic [MEAN_W-1:0]           mean_abs;
    logic                        mean_far_low;
    logic                        mean_low;
    logic                        mean_far_high;
    logic                        mean_high;
    logic                        cfg_write;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [DATA_W-1:0]           cfg_data;

    int mismatches;
    int outstanding;
    int compared;

    logic [DATA_W-1:0] reg_shadow [8];
    bit quiet_sender;
    bit quiet_receiver;
    int samples_sent;
    int evaluates_sent;
    int settings_applied;

    sample_range_and_mean_checker_core dut (.*);

    srmc_checker chk (.*);

    always #5 clk = ~clk;

    function automatic logic [DATA_W-1:0] q16(input int whole);
        return 32'(whole * 65536);
    endfunction

    function automatic logic [DATA_W-1:0] spread_signed();
        return $signed($urandom) >>> $urandom_range(0, 31);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        reg_shadow[idx] = data;
    endtask

    task automatic finish_writes();
        @(negedge clk);
        cfg_write <= 1'b0;
        settings_applied++;
    endtask

    task automatic send(input logic c, input logic [DATA_W-1:0] s);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        sample_in <= s;
        do @(posedge clk); while (!(in_valid && !in_stall));
        if (c == CMD_EVALUATE) begin
            evaluates_sent++;
        end
        else begin
            samples_sent++;
        end
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0: return reg_shadow[REG_MISSING_IN];
            1: return reg_shadow[REG_MISSING_OUT];
            2: begin
                case ($urandom_range(0, 4))
                    0: return WORD_MIN;
                    1: return WORD_MAX;
                    2: return 32'h0;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h1;
                endcase
            end
            3: return reg_shadow[REG_VALID_MIN] + 32'($urandom_range(0, 2)) - 32'd1;
            4: return reg_shadow[REG_VALID_MAX] + 32'($urandom_range(0, 2)) - 32'd1;
            5, 6: return spread_signed();
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] draw_code();
        case ($urandom_range(0, 4))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return 32'h0;
            3: return spread_signed();
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] draw_gain();
        case ($urandom_range(0, 5))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return SCALE_RESET;
            default: return $signed($urandom) >>> $urandom_range(8, 24);
        endcase
    endfunction

    task automatic configure_phase(input int k);
        if (k == 0) begin
            write_reg(REG_MISSING_IN, WORD_MIN);
            write_reg(REG_MISSING_OUT, WORD_MAX);
            write_reg(REG_SCALE, WORD_MIN);
            write_reg(REG_VALID_MIN, WORD_MIN);
            write_reg(REG_VALID_MAX, WORD_MAX);
            write_reg(REG_FLOOR, 32'hFFFF_FFFF);
            write_reg(REG_CEILING, 32'h0);
            write_reg(REG_ENABLES, 32'h1F);
        end
        else if (k == 1) begin
            write_reg(REG_MISSING_IN, WORD_MAX);
            write_reg(REG_MISSING_OUT, WORD_MIN);
            write_reg(REG_SCALE, WORD_MAX);
            write_reg(REG_VALID_MIN, WORD_MAX);
            write_reg(REG_VALID_MAX, WORD_MIN);
            write_reg(REG_FLOOR, 32'h0);
            write_reg(REG_CEILING, WORD_MAX);
            write_reg(REG_ENABLES, 32'h1F);
        end
        else begin
            write_reg(REG_MISSING_IN, draw_code());
            write_reg(REG_MISSING_OUT, draw_code());
            write_reg(REG_SCALE, draw_gain());
            write_reg(REG_VALID_MIN, spread_signed());
            write_reg(REG_VALID_MAX, spread_signed());
            write_reg(REG_FLOOR, $urandom >> $urandom_range(0, 31));
            write_reg(REG_CEILING, $urandom >> $urandom_range(0, 31));
            write_reg(REG_ENABLES, (k == 2) ? 32'h0 : 32'($urandom_range(0, 31)));
        end
        finish_writes();
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        cmd       = CMD_SAMPLE;
        sample_in = '0;
        out_stall = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_MISSING_IN;
        cfg_data  = '0;
        reg_shadow[REG_MISSING_IN]  = '0;
        reg_shadow[REG_MISSING_OUT] = '0;
        reg_shadow[REG_SCALE]       = SCALE_RESET;
        reg_shadow[REG_VALID_MIN]   = '0;
        reg_shadow[REG_VALID_MAX]   = '0;
        reg_shadow[REG_FLOOR]       = '0;
        reg_shadow[REG_CEILING]     = '0;
        reg_shadow[REG_ENABLES]     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // With the reset settings nothing is counted and a zero sample reads as missing.
        send(CMD_SAMPLE, q16(123));
        send(CMD_SAMPLE, 32'h0);
        send(CMD_EVALUATE, 32'h0);
        settle();

        write_reg(REG_MISSING_IN, q16(-9999));
        write_reg(REG_MISSING_OUT, q16(-999));
        write_reg(REG_SCALE, q16(2));
        write_reg(REG_VALID_MIN, q16(-100));
        write_reg(REG_VALID_MAX, q16(100));
        write_reg(REG_FLOOR, q16(50));
        write_reg(REG_CEILING, q16(60));
        write_reg(REG_ENABLES, 32'h1F);
        finish_writes();
        send(CMD_SAMPLE, q16(-9999));
        send(CMD_SAMPLE, q16(-999));
        send(CMD_SAMPLE, WORD_MAX);
        send(CMD_SAMPLE, WORD_MIN);
        send(CMD_SAMPLE, 32'h0);
        send(CMD_SAMPLE, 32'h1);
        send(CMD_SAMPLE, 32'hFFFF_FFFF);
        send(CMD_SAMPLE, q16(30));
        send(CMD_SAMPLE, q16(-150));
        send(CMD_SAMPLE, q16(80));
        // Scaling turns this one into the new missing code, so it is skipped.
        send(CMD_SAMPLE, 32'(-999 * 32768));
        send(CMD_EVALUATE, 32'h0);
        settle();

        // Half scale puts the products exactly halfway and exercises rounding of ties.
        write_reg(REG_SCALE, 32'h0000_8000);
        write_reg(REG_ENABLES, 32'((1 << EN_SCALE) | (1 << EN_FLOOR)));
        finish_writes();
        send(CMD_SAMPLE, 32'h1);
        send(CMD_SAMPLE, 32'hFFFF_FFFF);
        send(CMD_SAMPLE, 32'h3);
        send(CMD_SAMPLE, 32'hFFFF_FFFD);
        send(CMD_EVALUATE, 32'h0);
        settle();

        // The magnitude of the most negative sample pushes the mean past its limit.
        write_reg(REG_CEILING, 32'h1);
        write_reg(REG_ENABLES, 32'((1 << EN_RANGE) | (1 << EN_CEIL)));
        finish_writes();
        send(CMD_SAMPLE, WORD_MIN);
        send(CMD_SAMPLE, WORD_MIN);
        send(CMD_EVALUATE, 32'h0);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            configure_phase(p);
            quiet_sender   = ($urandom_range(0, 3) == 0);
            quiet_receiver = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_REQUESTS; i++) begin
                send(($urandom_range(0, 11) == 0) ? CMD_EVALUATE : CMD_SAMPLE, draw_sample());
            end
        end
        settle();
        repeat (100) @(posedge clk);

        $display("Sent %0d sample and %0d evaluate requests under %0d register settings.",
                 samples_sent, evaluates_sent, settings_applied);
        $display("Compared %0d results, %0d mismatches.", compared, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end
        else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : drain
        int hold;
        wait (rst_n);
        forever begin
            hold = quiet_receiver ? 0 : $urandom_range(0, 10);
            repeat (hold) begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    initial begin
        #6_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
